// ===== rtl/cte_pkg.sv =====
// ----------------------------------------------------------------------------
// cte_pkg: shared types and constants for the civil time converter
// Stage structures, calendar tables and range limits used by the pipeline.
// ----------------------------------------------------------------------------
package cte_pkg;

	// Accepted ranges of the record fields.
	localparam logic [15:0] YEAR_MIN = 16'd1900;
	localparam logic [15:0] YEAR_MAX = 16'd2100;
	localparam logic [7:0]  HOUR_MAX = 8'd23;
	localparam logic [7:0]  MINUTE_MAX = 8'd59;
	localparam logic signed [24:0] LAT_LIMIT_Q16 = 25'sd5898240;
	localparam logic signed [24:0] LON_LIMIT_Q16 = 25'sd11796480;

	// Calendar constants.
	localparam logic [15:0] ERA4_START = 16'd1600;
	localparam logic [15:0] ERA5_START = 16'd2000;
	localparam logic [17:0] DAYS_PER_YEAR = 18'd365;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [16:0] SECS_PER_MINUTE = 17'd60;
	localparam logic [34:0] SECS_PER_DAY = 35'd86400;

	// Seconds from 1970-01-01 to the start of era 4 (year 1600-03-01) and
	// era 5 (year 2000-03-01): (era * 146097 - 719468) * 86400.
	localparam logic signed [35:0] ERA4_SECONDS = -36'sd11670912000;
	localparam logic signed [35:0] ERA5_SECONDS = 36'sd951868800;

	// Stage 1: record checked, year split into era and year of era.
	typedef struct packed {
		logic               ok;
		logic               era5;
		logic [8:0]         yoe;
		logic [8:0]         doy;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic signed [17:0] zone;
	} s1_t;

	// Stage 2: day of era and local time of day shifted to UTC.
	typedef struct packed {
		logic               ok;
		logic               era5;
		logic [17:0]        doe;
		logic signed [18:0] tod;
	} s2_t;

	// Stage 3: day of era scaled to seconds.
	typedef struct packed {
		logic               ok;
		logic               era5;
		logic [34:0]        doe_secs;
		logic signed [18:0] tod;
	} s3_t;

	// Length of a month in a common year; codes outside 1..12 give zero.
	function automatic logic [7:0] month_len(input logic [7:0] month);
		logic [7:0] len;
		begin
			case (month)
				8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: len = 8'd31;
				8'd4, 8'd6, 8'd9, 8'd11:                    len = 8'd30;
				8'd2:                                       len = 8'd28;
				default:                                    len = 8'd0;
			endcase
			return len;
		end
	endfunction

	// Days from March 1 to the first of the month, (153 * mp + 2) / 5.
	function automatic logic [8:0] march_offset(input logic [7:0] month);
		logic [8:0] days;
		begin
			case (month)
				8'd3:    days = 9'd0;
				8'd4:    days = 9'd31;
				8'd5:    days = 9'd61;
				8'd6:    days = 9'd92;
				8'd7:    days = 9'd122;
				8'd8:    days = 9'd153;
				8'd9:    days = 9'd184;
				8'd10:   days = 9'd214;
				8'd11:   days = 9'd245;
				8'd12:   days = 9'd275;
				8'd1:    days = 9'd306;
				8'd2:    days = 9'd337;
				default: days = 9'd0;
			endcase
			return days;
		end
	endfunction

endpackage

// ===== rtl/cte_check.sv =====
// ----------------------------------------------------------------------------
// cte_check: record validation stage
// Checks every field of the record and splits the date into era, year of era
// and day of year counted from March.
// ----------------------------------------------------------------------------
module cte_check import cte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [15:0]        year_value,
	input  logic [7:0]         month_value,
	input  logic [7:0]         day_value,
	input  logic [7:0]         hour_value,
	input  logic [7:0]         minute_value,
	input  logic signed [17:0] zone_offset_seconds,
	input  logic signed [24:0] latitude_q16,
	input  logic signed [24:0] longitude_q16,
	input  logic               record_marked_valid,
	input  logic               name_present,
	output logic               valid_s1,
	output s1_t                data_s1
);

	logic        leap;
	logic [7:0]  max_day;
	logic        fields_ok;
	logic [15:0] adj_year;
	logic        era5;
	logic [15:0] yoe_full;
	logic [8:0]  doy;
	s1_t         next_s1;

	// Leap rule restricted to 1900..2100: only 2000 is a century leap year.
	assign leap = (year_value[1:0] == 2'b00) && (year_value != YEAR_MIN) &&
		(year_value != YEAR_MAX);

	always_comb begin
		max_day = month_len(month_value);
		if ((month_value == 8'd2) && leap) begin
			max_day = 8'd29;
		end
	end

	// All range checks in parallel.
	assign fields_ok = record_marked_valid && name_present &&
		(year_value >= YEAR_MIN) && (year_value <= YEAR_MAX) &&
		(month_value >= 8'd1) && (month_value <= 8'd12) &&
		(day_value >= 8'd1) && (day_value <= max_day) &&
		(hour_value <= HOUR_MAX) && (minute_value <= MINUTE_MAX) &&
		(latitude_q16 >= -LAT_LIMIT_Q16) && (latitude_q16 <= LAT_LIMIT_Q16) &&
		(longitude_q16 >= -LON_LIMIT_Q16) && (longitude_q16 <= LON_LIMIT_Q16);

	// January and February belong to the previous year of the March-based calendar.
	assign adj_year = year_value - {15'd0, (month_value <= 8'd2)};
	assign era5     = (adj_year >= ERA5_START);
	assign yoe_full = adj_year - (era5 ? ERA5_START : ERA4_START);
	assign doy      = march_offset(month_value) + {1'b0, day_value} - 9'd1;

	always_comb begin
		next_s1.ok     = fields_ok;
		next_s1.era5   = era5;
		next_s1.yoe    = yoe_full[8:0];
		next_s1.doy    = doy;
		next_s1.hour   = hour_value[4:0];
		next_s1.minute = minute_value[5:0];
		next_s1.zone   = zone_offset_seconds;
	end

	// Valid bit of stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of stage 1.
	always_ff @(posedge clk) begin
		if (in_valid) begin
			data_s1 <= next_s1;
		end
	end

endmodule

// ===== rtl/cte_day_count.sv =====
// ----------------------------------------------------------------------------
// cte_day_count: day of era and time of day stage
// Counts days inside the 400-year era and turns the local time of day into
// seconds relative to UTC.
// ----------------------------------------------------------------------------
module cte_day_count import cte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_s1,
	input  s1_t  data_s1,
	output logic valid_s2,
	output s2_t  data_s2
);

	logic [17:0]        year_days;
	logic [1:0]         centuries;
	logic [17:0]        doe;
	logic [16:0]        local_secs;
	logic signed [18:0] tod;
	s2_t                next_s2;

	// Whole centuries in the year of era, which stays below 400.
	always_comb begin
		if (data_s1.yoe >= 9'd300) begin
			centuries = 2'd3;
		end else if (data_s1.yoe >= 9'd200) begin
			centuries = 2'd2;
		end else if (data_s1.yoe >= 9'd100) begin
			centuries = 2'd1;
		end else begin
			centuries = 2'd0;
		end
	end

	// Day of era: 365 per year, a leap day every fourth, none on centuries.
	assign year_days = 18'(data_s1.yoe) * DAYS_PER_YEAR;
	assign doe = year_days + 18'(data_s1.yoe[8:2]) - 18'(centuries) + 18'(data_s1.doy);

	// Time of day minus zone offset.
	assign local_secs = 17'(data_s1.hour) * SECS_PER_HOUR +
		17'(data_s1.minute) * SECS_PER_MINUTE;
	assign tod = $signed({2'b00, local_secs}) - $signed({data_s1.zone[17], data_s1.zone});

	always_comb begin
		next_s2.ok   = data_s1.ok;
		next_s2.era5 = data_s1.era5;
		next_s2.doe  = doe;
		next_s2.tod  = tod;
	end

	// Valid bit of stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Payload of stage 2.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			data_s2 <= next_s2;
		end
	end

endmodule

// ===== rtl/cte_scale.sv =====
// ----------------------------------------------------------------------------
// cte_scale: seconds scaling and final sum
// Multiplies the day of era by the seconds in a day, then adds the era start
// and the UTC time of day into the result register.
// ----------------------------------------------------------------------------
module cte_scale import cte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s2,
	input  s2_t                data_s2,
	output logic               valid_s4,
	output logic               ok_s4,
	output logic signed [32:0] secs_s4
);

	logic               valid_s3;
	s3_t                data_s3;
	s3_t                next_s3;
	logic signed [35:0] total;

	always_comb begin
		next_s3.ok       = data_s2.ok;
		next_s3.era5     = data_s2.era5;
		next_s3.doe_secs = 35'(data_s2.doe) * SECS_PER_DAY;
		next_s3.tod      = data_s2.tod;
	end

	// Era start plus day seconds plus time of day.
	assign total = $signed({1'b0, data_s3.doe_secs}) +
		(data_s3.era5 ? ERA5_SECONDS : ERA4_SECONDS) +
		36'(data_s3.tod);

	// Valid bits of stages 3 and 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Payload of stages 3 and 4; a rejected record reports zero seconds.
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			data_s3 <= next_s3;
		end
		if (valid_s3) begin
			ok_s4   <= data_s3.ok;
			secs_s4 <= data_s3.ok ? total[32:0] : 33'sd0;
		end
	end

endmodule

// ===== rtl/civil_time_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds: civil date and time to UTC epoch seconds
// Validates a local date/time record and converts it to seconds since
// 1970-01-01 UTC with the days-from-civil formula.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   command  | start, busy, record fields                | in
//   result   | done, conversion_ok, utc_seconds          | out
//
// A transaction is taken at every edge with start high; busy stays low.
// Done follows start through the four register stages (check, day count,
// multiply, sum); one record per cycle sustained.
// Reset clears only the stage valid bits; no result appears after reset
// until a record is taken. The receiver cannot stall, so nothing holds back.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds import cte_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        year_value,
	input  logic [7:0]         month_value,
	input  logic [7:0]         day_value,
	input  logic [7:0]         hour_value,
	input  logic [7:0]         minute_value,
	input  logic signed [17:0] zone_offset_seconds,
	input  logic signed [24:0] latitude_q16,
	input  logic signed [24:0] longitude_q16,
	input  logic               record_marked_valid,
	input  logic               name_present,
	output logic               done,
	output logic               conversion_ok,
	output logic signed [32:0] utc_seconds
);

	logic in_valid;
	logic valid_s1;
	s1_t  data_s1;
	logic valid_s2;
	s2_t  data_s2;

	// The pipeline never stalls, so a command is always taken.
	assign busy     = 1'b0;
	assign in_valid = start && !busy;

	cte_check u_check (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.year_value          (year_value),
		.month_value         (month_value),
		.day_value           (day_value),
		.hour_value          (hour_value),
		.minute_value        (minute_value),
		.zone_offset_seconds (zone_offset_seconds),
		.latitude_q16        (latitude_q16),
		.longitude_q16       (longitude_q16),
		.record_marked_valid (record_marked_valid),
		.name_present        (name_present),
		.valid_s1            (valid_s1),
		.data_s1             (data_s1)
	);

	cte_day_count u_day_count (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	cte_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.valid_s4 (done),
		.ok_s4    (conversion_ok),
		.secs_s4  (utc_seconds)
	);

endmodule

// ===== tb/civil_time_to_epoch_seconds_test.sv =====
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds_test: self-checking bench for the epoch converter
// Drives a table of directed date/time records and then random records, mostly
// well formed with random content and some broken on purpose. Each result is
// matched in order against the typed-in value or a behavioral converter.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds_test import cte_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// One local date/time record as it enters the converter.
	typedef struct packed {
		logic [15:0]        year;
		logic [7:0]         month;
		logic [7:0]         day;
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic signed [17:0] zone;
		logic signed [24:0] lat;
		logic signed [24:0] lon;
		logic               marked_valid;
		logic               named;
	} civil_record_t;

	// One conversion result.
	typedef struct packed {
		logic               ok;
		logic signed [32:0] secs;
	} epoch_result_t;

	// A directed row: the record, and the result where it is typed in.
	typedef struct packed {
		civil_record_t rec;
		logic          known;
		epoch_result_t known_result;
	} directed_row_t;

	localparam int  DIRECTED_COUNT = 26;
	localparam int  RANDOM_PER_PHASE = 267;
	localparam int  STALL_LIMIT = 200;
	localparam int  DRAIN_CYCLES = 8;
	localparam longint DAYS_IN_ERA = 146097;
	localparam longint DAYS_TO_EPOCH = 719468;
	localparam longint SECONDS_IN_DAY = 86400;
	localparam logic signed [32:0] REJECTED = 33'sd0;

	// Columns: year, month, day, hour, minute, zone, latitude, longitude,
	// valid flag, name flag; then whether the result is typed in, and the result.
	localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
		'{'{16'd1970, 8'd1, 8'd1, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b1, 33'sd0}},
		'{'{16'd1970, 8'd1, 8'd1, 8'd0, 8'd0, 3600, 0, 0, 1'b1, 1'b1},
			1'b1, '{1'b1, -33'sd3600}},
		'{'{16'd2000, 8'd3, 8'd1, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1},
			1'b1, '{1'b1, 33'sd951868800}},
		'{'{16'd1900, 8'd1, 8'd1, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1},
			1'b1, '{1'b1, -33'sd2208988800}},
		'{'{16'd2100, 8'd12, 8'd31, 8'd23, 8'd59, -131072, 5898240, 11796480, 1'b1, 1'b1},
			1'b0, '{1'b0, REJECTED}},
		'{'{16'd2100, 8'd12, 8'd31, 8'd23, 8'd59, 131071, -5898240, -11796480, 1'b1, 1'b1},
			1'b0, '{1'b0, REJECTED}},
		'{'{16'd1899, 8'd12, 8'd31, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2101, 8'd1, 8'd1, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd65535, 8'd255, 8'd255, 8'd255, 8'd255, -1, 16777215, -16777216, 1'b1, 1'b1},
			1'b1, '{1'b0, REJECTED}},
		'{'{16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd1, 8'd0, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd1, 8'd32, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2000, 8'd2, 8'd29, 8'd6, 8'd30, 0, 0, 0, 1'b1, 1'b1}, 1'b0, '{1'b0, REJECTED}},
		'{'{16'd1900, 8'd2, 8'd29, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2100, 8'd2, 8'd29, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2024, 8'd2, 8'd29, 8'd12, 8'd0, -18000, 0, 0, 1'b1, 1'b1},
			1'b0, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd2, 8'd29, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd4, 8'd31, 8'd0, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd24, 8'd0, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd60, 0, 0, 0, 1'b1, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd0, 0, 5898241, 0, 1'b1, 1'b1},
			1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd0, 0, -16777216, 0, 1'b1, 1'b1},
			1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd0, 0, 0, 11796481, 1'b1, 1'b1},
			1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd0, 0, 0, -11796481, 1'b1, 1'b1},
			1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd0, 0, 0, 0, 1'b0, 1'b1}, 1'b1, '{1'b0, REJECTED}},
		'{'{16'd2023, 8'd6, 8'd15, 8'd12, 8'd0, 0, 0, 0, 1'b1, 1'b0}, 1'b1, '{1'b0, REJECTED}}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [15:0]        year_value;
	logic [7:0]         month_value;
	logic [7:0]         day_value;
	logic [7:0]         hour_value;
	logic [7:0]         minute_value;
	logic signed [17:0] zone_offset_seconds;
	logic signed [24:0] latitude_q16;
	logic signed [24:0] longitude_q16;
	logic               record_marked_valid;
	logic               name_present;
	logic               done;
	logic               conversion_ok;
	logic signed [32:0] utc_seconds;

	epoch_result_t expected_results[$];
	int            error_count = 0;
	int            quiet_cycles = 0;

	civil_time_to_epoch_seconds uut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.year_value          (year_value),
		.month_value         (month_value),
		.day_value           (day_value),
		.hour_value          (hour_value),
		.minute_value        (minute_value),
		.zone_offset_seconds (zone_offset_seconds),
		.latitude_q16        (latitude_q16),
		.longitude_q16       (longitude_q16),
		.record_marked_valid (record_marked_valid),
		.name_present        (name_present),
		.done                (done),
		.conversion_ok       (conversion_ok),
		.utc_seconds         (utc_seconds)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Length of a month with Gregorian leap years; zero for an illegal month.
	function automatic int unsigned days_in_month(input int unsigned year,
			input int unsigned month);
		int unsigned len;
		begin
			case (month)
				1, 3, 5, 7, 8, 10, 12: len = 31;
				4, 6, 9, 11:           len = 30;
				2: begin
					if ((year % 4 == 0 && year % 100 != 0) || year % 400 == 0)
						len = 29;
					else
						len = 28;
				end
				default:               len = 0;
			endcase
			return len;
		end
	endfunction

	// Checks a record and converts it to UTC seconds by the days-from-civil method.
	function automatic epoch_result_t civil_to_utc(input civil_record_t rec);
		epoch_result_t res;
		longint        shifted_year;
		longint        era;
		longint        year_of_era;
		longint        march_month;
		longint        day_of_year;
		longint        day_of_era;
		longint        days;
		longint        secs;
		begin
			res.ok = rec.marked_valid && rec.named &&
				rec.year >= YEAR_MIN && rec.year <= YEAR_MAX &&
				rec.month >= 8'd1 && rec.month <= 8'd12 &&
				rec.day >= 8'd1 && rec.day <= days_in_month(rec.year, rec.month) &&
				rec.hour <= HOUR_MAX && rec.minute <= MINUTE_MAX &&
				int'(rec.lat) >= -int'(LAT_LIMIT_Q16) && int'(rec.lat) <= int'(LAT_LIMIT_Q16) &&
				int'(rec.lon) >= -int'(LON_LIMIT_Q16) && int'(rec.lon) <= int'(LON_LIMIT_Q16);
			res.secs = '0;
			if (res.ok) begin
				// The year is taken to start on March 1, so leap days come last.
				shifted_year = longint'(rec.year) - ((rec.month <= 8'd2) ? 1 : 0);
				era = shifted_year / 400;
				year_of_era = shifted_year - era * 400;
				march_month = (rec.month > 8'd2) ? longint'(rec.month) - 3 :
					longint'(rec.month) + 9;
				day_of_year = (153 * march_month + 2) / 5 + longint'(rec.day) - 1;
				day_of_era = year_of_era * 365 + year_of_era / 4 - year_of_era / 100 +
					day_of_year;
				days = era * DAYS_IN_ERA + day_of_era - DAYS_TO_EPOCH;
				secs = days * SECONDS_IN_DAY + longint'(rec.hour) * 3600 +
					longint'(rec.minute) * 60 - longint'(rec.zone);
				res.secs = secs[32:0];
			end
			return res;
		end
	endfunction

	// Random record: mostly legal with random content, the rest broken in one
	// field or pure noise.
	function automatic civil_record_t random_record();
		civil_record_t rec;
		int unsigned   last_day;
		begin
			rec.year = 16'($urandom_range(1900, 2100));
			rec.month = 8'($urandom_range(1, 12));
			last_day = days_in_month(rec.year, rec.month);
			rec.day = ($urandom_range(0, 7) == 0) ? 8'(last_day) :
				8'($urandom_range(1, last_day));
			rec.hour = 8'($urandom_range(0, 23));
			rec.minute = 8'($urandom_range(0, 59));
			rec.zone = ($urandom_range(0, 9) == 0) ? 18'($urandom) :
				18'(int'($urandom_range(0, 172800)) - 86400);
			rec.lat = ($urandom_range(0, 9) == 0) ?
				(($urandom_range(0, 1) == 0) ? LAT_LIMIT_Q16 : -LAT_LIMIT_Q16) :
				25'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
			rec.lon = ($urandom_range(0, 9) == 0) ?
				(($urandom_range(0, 1) == 0) ? LON_LIMIT_Q16 : -LON_LIMIT_Q16) :
				25'(int'($urandom_range(0, 2 * 11796480)) - 11796480);
			rec.marked_valid = 1'b1;
			rec.named = 1'b1;
			if ($urandom_range(0, 99) < 30) begin
				case ($urandom_range(0, 9))
					0: rec.year = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1899)) :
						16'($urandom_range(2101, 65535));
					1: rec.month = ($urandom_range(0, 1) == 0) ? 8'd0 :
						8'($urandom_range(13, 255));
					2: rec.day = ($urandom_range(0, 1) == 0) ? 8'd0 :
						8'($urandom_range(last_day + 1, 255));
					3: rec.hour = 8'($urandom_range(24, 255));
					4: rec.minute = 8'($urandom_range(60, 255));
					5: rec.lat = ($urandom_range(0, 1) == 0) ?
						25'($urandom_range(5898241, 16777215)) :
						25'(-int'($urandom_range(5898241, 16777216)));
					6: rec.lon = ($urandom_range(0, 1) == 0) ?
						25'($urandom_range(11796481, 16777215)) :
						25'(-int'($urandom_range(11796481, 16777216)));
					7: rec.marked_valid = 1'b0;
					8: rec.named = 1'b0;
					default: begin
						rec.year = 16'($urandom);
						rec.month = 8'($urandom);
						rec.day = 8'($urandom);
						rec.hour = 8'($urandom);
						rec.minute = 8'($urandom);
						rec.zone = 18'($urandom);
						rec.lat = 25'($urandom);
						rec.lon = 25'($urandom);
						rec.marked_valid = 1'($urandom);
						rec.named = 1'($urandom);
					end
				endcase
			end
			return rec;
		end
	endfunction

	// Presents one record and waits until the converter takes it, then files
	// the result it must produce.
	task automatic send_record(input civil_record_t rec, input logic known,
			input epoch_result_t known_result);
		begin
			start <= 1'b1;
			year_value <= rec.year;
			month_value <= rec.month;
			day_value <= rec.day;
			hour_value <= rec.hour;
			minute_value <= rec.minute;
			zone_offset_seconds <= rec.zone;
			latitude_q16 <= rec.lat;
			longitude_q16 <= rec.lon;
			record_marked_valid <= rec.marked_valid;
			name_present <= rec.named;
			do
				@(posedge clk);
			while (busy !== 1'b0);
			expected_results.push_back(known ? known_result : civil_to_utc(rec));
		end
	endtask

	// Sender idles each following cycle with the given chance in percent.
	task automatic maybe_pause(input int unsigned pause_pct);
		begin
			while ($urandom_range(0, 99) < pause_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	// Stimulus: reset, directed table, three random phases, then drain.
	initial begin
		int unsigned pause_pct;
		arst_n <= 1'b0;
		start <= 1'b0;
		year_value <= '0;
		month_value <= '0;
		day_value <= '0;
		hour_value <= '0;
		minute_value <= '0;
		zone_offset_seconds <= '0;
		latitude_q16 <= '0;
		longitude_q16 <= '0;
		record_marked_valid <= 1'b0;
		name_present <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < DIRECTED_COUNT; row++) begin
			send_record(DIRECTED_ROWS[row].rec, DIRECTED_ROWS[row].known,
				DIRECTED_ROWS[row].known_result);
		end

		for (int phase = 0; phase < 3; phase++) begin
			pause_pct = (phase == 0) ? 18 : (phase == 1) ? 54 : 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_record(random_record(), 1'b0, '0);
				maybe_pause(pause_pct);
			end
		end
		start <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS civil_time_to_epoch_seconds");
		else
			$display("FAIL civil_time_to_epoch_seconds");
		$finish;
	end

	// Result checker: each done pulse is matched against the oldest expectation.
	always @(posedge clk) begin
		epoch_result_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result ok=%0b seconds=%0d", $time, conversion_ok,
					utc_seconds);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (conversion_ok !== want.ok) begin
					$display("%0t: conversion_ok expected %0b actual %0b", $time, want.ok,
						conversion_ok);
					error_count++;
				end
				if (utc_seconds !== want.secs) begin
					$display("%0t: utc_seconds expected %0d actual %0d", $time, want.secs,
						utc_seconds);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL civil_time_to_epoch_seconds");
				$finish;
			end
		end
	end

endmodule
